>>> hdl/smba_pkg.sv
// Shared types and constants for the size matched buffer allocator.
// Used by smba_cell and size_matched_buffer_allocator_unit; depends on nothing.
package smba_pkg;

	localparam int SIZE_W  = 40;
	localparam int HI_W    = 45;
	localparam int TOTAL_W = 46;
	localparam int STAMP_W = 32;
	localparam int TAG_W   = 4;
	localparam int ID_W    = 7;
	localparam int CNT_W   = 38;
	localparam int RANGE_W = 5;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_BAD_ID  = 2'd1;
	localparam logic [1:0] STAT_FULL    = 2'd2;
	localparam logic [1:0] STAT_INVALID = 2'd3;

	localparam logic [ID_W-1:0] ID_BAD = 7'h7f;
	localparam logic [ID_W-1:0] ID_EXT = 7'h7e;
	localparam logic [ID_W-1:0] ID_DYN = 7'h7d;

	localparam logic [1:0] CFG_RANGE      = 2'd0;
	localparam logic [1:0] CFG_USE_COLORS = 2'd1;

	localparam logic FUNC_REQUEST = 1'b0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} smba_state_t;

	// Request context shared by every cell during a scan.
	typedef struct packed {
		logic [SIZE_W-1:0]  bytes;
		logic [HI_W-1:0]    hi;
		logic [RANGE_W-1:0] mrange;
		logic [TAG_W-1:0]   dev;
		logic [TAG_W-1:0]   color;
		logic               use_colors;
		logic [STAMP_W-1:0] rel_cnt;
	} smba_req_t;

	// Search record handed from cell to cell.
	typedef struct packed {
		logic               tok;
		logic               fit_ok;
		logic [SIZE_W-1:0]  fit_size;
		logic [STAMP_W-1:0] fit_age;
		logic               grow_ok;
		logic [SIZE_W-1:0]  grow_size;
		logic [STAMP_W-1:0] grow_age;
	} smba_rec_t;

	// Entry update command.
	typedef struct packed {
		logic               alloc;
		logic               grow;
		logic               take;
		logic               rel;
		logic [SIZE_W-1:0]  size;
		logic [TAG_W-1:0]   dev;
		logic [TAG_W-1:0]   color;
		logic [STAMP_W-1:0] stamp;
	} smba_wr_t;

endpackage

>>> hdl/smba_cell.sv
// One table entry of the allocator plus its stage of the search chain.
// Depends on smba_pkg.
module smba_cell #(
	parameter int IDX_W = 6,
	parameter int INDEX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  smba_pkg::smba_req_t req,
	input  smba_pkg::smba_wr_t  wr,
	input  logic [IDX_W-1:0]    wr_idx,
	input  smba_pkg::smba_rec_t rec_in,
	input  logic [IDX_W-1:0]    fit_idx_in,
	input  logic [IDX_W-1:0]    grow_idx_in,
	output smba_pkg::smba_rec_t rec_out,
	output logic [IDX_W-1:0]    fit_idx_out,
	output logic [IDX_W-1:0]    grow_idx_out
);

	logic [smba_pkg::SIZE_W-1:0]  size_q;
	logic [smba_pkg::TAG_W-1:0]   dev_q;
	logic [smba_pkg::TAG_W-1:0]   color_q;
	logic [smba_pkg::STAMP_W-1:0] stamp_q;
	logic                         free_q;

	logic                           hit;
	logic                           elig;
	logic [smba_pkg::STAMP_W-1:0]   age;
	logic [smba_pkg::HI_W-1:0]      prod;
	logic [smba_pkg::TOTAL_W-1:0]   upper;
	logic                           in_fit;
	logic                           in_grow;
	logic                           take_fit;
	logic                           take_grow;
	smba_pkg::smba_rec_t            nxt;
	logic [IDX_W-1:0]               nxt_fit_idx;
	logic [IDX_W-1:0]               nxt_grow_idx;

	assign hit = (wr_idx == IDX_W'(INDEX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q  <= 1'b0;
			color_q <= '0;
		end else if (hit) begin
			if (wr.alloc || wr.grow || wr.take) begin
				free_q <= 1'b0;
			end else if (wr.rel) begin
				free_q  <= 1'b1;
				color_q <= wr.color;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit) begin
			if (wr.alloc || wr.grow) begin
				size_q <= wr.size;
			end
			if (wr.alloc) begin
				dev_q <= wr.dev;
			end
			if (wr.rel) begin
				stamp_q <= wr.stamp;
			end
		end
	end

	// Lower bound bytes/range is tested as bytes <= size*range + range - 1.
	always_comb begin
		elig  = free_q && (dev_q == req.dev) && (!req.use_colors || (color_q == req.color));
		age   = req.rel_cnt - stamp_q;
		prod  = smba_pkg::HI_W'(size_q) * smba_pkg::HI_W'(req.mrange);
		upper = smba_pkg::TOTAL_W'(prod) + smba_pkg::TOTAL_W'(req.mrange)
			- smba_pkg::TOTAL_W'(1);
		in_fit  = elig && (size_q >= req.bytes) && (smba_pkg::HI_W'(size_q) <= req.hi);
		in_grow = elig && (size_q < req.bytes)
			&& (smba_pkg::TOTAL_W'(req.bytes) <= upper);
		take_fit = in_fit && (!rec_in.fit_ok || (size_q < rec_in.fit_size)
			|| ((size_q == rec_in.fit_size) && (age > rec_in.fit_age)));
		take_grow = in_grow && (!rec_in.grow_ok || (size_q > rec_in.grow_size)
			|| ((size_q == rec_in.grow_size) && (age < rec_in.grow_age)));
		nxt          = rec_in;
		nxt_fit_idx  = fit_idx_in;
		nxt_grow_idx = grow_idx_in;
		if (take_fit) begin
			nxt.fit_ok   = 1'b1;
			nxt.fit_size = size_q;
			nxt.fit_age  = age;
			nxt_fit_idx  = IDX_W'(INDEX);
		end
		if (take_grow) begin
			nxt.grow_ok   = 1'b1;
			nxt.grow_size = size_q;
			nxt.grow_age  = age;
			nxt_grow_idx  = IDX_W'(INDEX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_out      <= '0;
			fit_idx_out  <= '0;
			grow_idx_out <= '0;
		end else begin
			rec_out      <= nxt;
			fit_idx_out  <= nxt_fit_idx;
			grow_idx_out <= nxt_grow_idx;
		end
	end

endmodule

>>> hdl/size_matched_buffer_allocator_unit.sv
// Top level of the size matched buffer allocator: control, totals and the cell chain.
// Depends on smba_pkg and smba_cell.
//
// Channel  Direction  Signals                         Use
// s_       in         s_tvalid s_tready s_tdata s_tuser  request or release
// m_       out        m_tvalid m_tready m_tdata          grant, status, total
// cfg_     in         cfg_valid cfg_ready cfg_index cfg_data  register write
//
// A release, or a request without shape or with a zero range setting, goes straight from
// idle to the finish state; a searched request first has its search token walk the cell
// chain one entry per cycle and then finishes. In the finish state the result is written
// to the output register once that register is free, and the unit returns to idle to take
// the next input. One item is in work at a time; the output register holds a result while
// the next item is accepted, and an untaken result stalls the next one before its table
// update. Reset leaves the table empty with no clearing pass.
module size_matched_buffer_allocator_unit #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// dev[3:0], has_shape[4], element_count[42:5], node_color[46:43],
	// release_id[53:47], zero[55:54]
	input  logic [55:0] s_tdata,
	// func[0]
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// grant[6:0], status[8:7], total_bytes[54:9], zero[55]
	output logic [55:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [4:0]  cfg_data
);

	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int UW = $clog2(MAX_ENTRIES + 1);
	localparam int CW = (UW > smba_pkg::ID_W) ? UW : smba_pkg::ID_W;

	smba_pkg::smba_state_t state_q, state_nxt;

	logic                            func_q;
	logic [smba_pkg::TAG_W-1:0]      dev_q;
	logic                            shape_q;
	logic [smba_pkg::SIZE_W-1:0]     bytes_q;
	logic [smba_pkg::TAG_W-1:0]      color_q;
	logic [smba_pkg::ID_W-1:0]       rid_q;
	logic [smba_pkg::HI_W-1:0]       hi_q;
	logic                            start_q;
	logic [smba_pkg::RANGE_W-1:0]    mrange_q;
	logic                            usecol_q;
	logic [UW-1:0]                   used_q;
	logic [smba_pkg::STAMP_W-1:0]    relcnt_q;
	logic [smba_pkg::TOTAL_W-1:0]    total_q;
	logic                            fit_ok_q;
	logic                            grow_ok_q;
	logic [IW-1:0]                   fit_idx_q;
	logic [IW-1:0]                   grow_idx_q;
	logic [smba_pkg::SIZE_W-1:0]     grow_size_q;
	logic                            m_tvalid_q;
	logic [55:0]                     m_tdata_q;

	logic                            accept;
	logic                            go_scan;
	logic                            fin_go;
	logic [smba_pkg::SIZE_W-1:0]     in_bytes;
	smba_pkg::smba_req_t             req;
	smba_pkg::smba_wr_t              wr;
	logic [IW-1:0]                   wr_idx;
	logic [smba_pkg::ID_W-1:0]       out_id;
	logic [1:0]                      out_stat;
	logic [smba_pkg::TOTAL_W-1:0]    total_nxt;
	logic [UW-1:0]                   used_nxt;
	logic [smba_pkg::STAMP_W-1:0]    relcnt_nxt;

	smba_pkg::smba_rec_t             rec [0:MAX_ENTRIES];
	logic [IW-1:0]                   fidx [0:MAX_ENTRIES];
	logic [IW-1:0]                   gidx [0:MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0]          tok_vec;

	assign in_bytes = {s_tdata[42:5], 2'b00};
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	// Control outputs.
	always_comb begin
		s_tready = (state_q == smba_pkg::ST_IDLE);
		accept   = s_tvalid && s_tready;
		go_scan  = (s_tuser == smba_pkg::FUNC_REQUEST) && s_tdata[4] && (mrange_q != '0);
		fin_go   = (state_q == smba_pkg::ST_FIN) && (!m_tvalid_q || m_tready);
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			smba_pkg::ST_IDLE: begin
				if (accept) begin
					state_nxt = go_scan ? smba_pkg::ST_SCAN : smba_pkg::ST_FIN;
				end
			end
			smba_pkg::ST_SCAN: begin
				if (rec[MAX_ENTRIES].tok) begin
					state_nxt = smba_pkg::ST_FIN;
				end
			end
			smba_pkg::ST_FIN: begin
				if (fin_go) begin
					state_nxt = smba_pkg::ST_IDLE;
				end
			end
			default: state_nxt = smba_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= smba_pkg::ST_IDLE;
			start_q  <= 1'b0;
			mrange_q <= 5'd2;
			usecol_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			start_q <= accept && go_scan;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					smba_pkg::CFG_RANGE:      mrange_q <= cfg_data;
					smba_pkg::CFG_USE_COLORS: usecol_q <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= s_tuser;
			dev_q   <= s_tdata[3:0];
			shape_q <= s_tdata[4];
			bytes_q <= in_bytes;
			color_q <= s_tdata[46:43];
			rid_q   <= s_tdata[53:47];
			hi_q    <= smba_pkg::HI_W'(in_bytes) * smba_pkg::HI_W'(mrange_q);
		end
		if (state_q == smba_pkg::ST_SCAN && rec[MAX_ENTRIES].tok) begin
			fit_idx_q   <= fidx[MAX_ENTRIES];
			grow_idx_q  <= gidx[MAX_ENTRIES];
			grow_size_q <= rec[MAX_ENTRIES].grow_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_ok_q  <= 1'b0;
			grow_ok_q <= 1'b0;
		end else if (accept) begin
			fit_ok_q  <= 1'b0;
			grow_ok_q <= 1'b0;
		end else if (state_q == smba_pkg::ST_SCAN && rec[MAX_ENTRIES].tok) begin
			fit_ok_q  <= rec[MAX_ENTRIES].fit_ok;
			grow_ok_q <= rec[MAX_ENTRIES].grow_ok;
		end
	end

	// Outcome of the item in work, applied when the output register is free.
	always_comb begin
		wr         = '0;
		wr.size    = bytes_q;
		wr.dev     = dev_q;
		wr.color   = color_q;
		wr.stamp   = relcnt_q;
		wr_idx     = '0;
		out_id     = smba_pkg::ID_BAD;
		out_stat   = smba_pkg::STAT_OK;
		total_nxt  = total_q;
		used_nxt   = used_q;
		relcnt_nxt = relcnt_q;
		if (func_q != smba_pkg::FUNC_REQUEST) begin
			if (rid_q == smba_pkg::ID_BAD) begin
				out_stat = smba_pkg::STAT_BAD_ID;
			end else if (rid_q == smba_pkg::ID_EXT || rid_q == smba_pkg::ID_DYN) begin
				out_stat = smba_pkg::STAT_OK;
			end else if (rid_q[smba_pkg::ID_W-1]
				|| (CW'(rid_q) >= CW'(used_q))) begin
				out_stat = smba_pkg::STAT_INVALID;
			end else begin
				wr.rel     = fin_go;
				wr_idx     = IW'(rid_q);
				relcnt_nxt = relcnt_q + smba_pkg::STAMP_W'(1);
			end
		end else if (shape_q) begin
			if (fit_ok_q) begin
				wr.take = fin_go;
				wr_idx  = fit_idx_q;
				out_id  = smba_pkg::ID_W'(fit_idx_q);
			end else if (grow_ok_q) begin
				wr.grow   = fin_go;
				wr_idx    = grow_idx_q;
				out_id    = smba_pkg::ID_W'(grow_idx_q);
				total_nxt = total_q + smba_pkg::TOTAL_W'(bytes_q)
					- smba_pkg::TOTAL_W'(grow_size_q);
			end else if (CW'(used_q) >= CW'(MAX_ENTRIES)) begin
				out_stat = smba_pkg::STAT_FULL;
			end else begin
				wr.alloc  = fin_go;
				wr_idx    = IW'(used_q);
				out_id    = smba_pkg::ID_W'(used_q);
				total_nxt = total_q + smba_pkg::TOTAL_W'(bytes_q);
				used_nxt  = used_q + UW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			relcnt_q   <= '0;
			total_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (fin_go) begin
				used_q     <= used_nxt;
				relcnt_q   <= relcnt_nxt;
				total_q    <= total_nxt;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			m_tdata_q <= {1'b0, total_nxt, out_stat, out_id};
		end
	end

	always_comb begin
		req.bytes      = bytes_q;
		req.hi         = hi_q;
		req.mrange     = mrange_q;
		req.dev        = dev_q;
		req.color      = color_q;
		req.use_colors = usecol_q;
		req.rel_cnt    = relcnt_q;
		rec[0]         = '0;
		rec[0].tok     = start_q;
		fidx[0]        = '0;
		gidx[0]        = '0;
	end

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		smba_cell #(
			.IDX_W (IW),
			.INDEX (i)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.req          (req),
			.wr           (wr),
			.wr_idx       (wr_idx),
			.rec_in       (rec[i]),
			.fit_idx_in   (fidx[i]),
			.grow_idx_in  (gidx[i]),
			.rec_out      (rec[i+1]),
			.fit_idx_out  (fidx[i+1]),
			.grow_idx_out (gidx[i+1])
		);
		assign tok_vec[i] = rec[i+1].tok;
	end

	// Only one search token may be in the chain.
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vec))
		else $error("more than one search token in the cell chain");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(used_q) <= CW'(MAX_ENTRIES))
		else $error("entry count beyond table depth");

	a_fit_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == smba_pkg::ST_FIN && fit_ok_q) |-> (CW'(fit_idx_q) < CW'(used_q)))
		else $error("reuse picked an entry that was never allocated");

	a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == smba_pkg::ST_SCAN) |-> !s_tready)
		else $error("input taken during a table search");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for size_matched_buffer_allocator_unit: a table model
// predicts every grant, status and byte total. Depends on smba_pkg and the RTL.
module tb;
	import smba_pkg::*;

	localparam int         NUM_ENTRIES  = 64;
	localparam logic       FUNC_RELEASE = 1'b1;
	localparam int         IDLE_LIMIT   = 5000;
	localparam int         DRAIN_CYCLES = NUM_ENTRIES + 16;

	typedef struct packed {
		logic [TOTAL_W-1:0] total;
		logic [1:0]         status;
		logic [ID_W-1:0]    id;
	} grant_t;

	// Table model of the allocator plus the queue of grants it still owes.
	class allocator_scoreboard;
		logic [SIZE_W-1:0]  size_tab [NUM_ENTRIES];
		logic [TAG_W-1:0]   dev_tab [NUM_ENTRIES];
		logic [TAG_W-1:0]   color_tab [NUM_ENTRIES];
		logic               free_tab [NUM_ENTRIES];
		logic [STAMP_W-1:0] stamp_tab [NUM_ENTRIES];
		int                 used;
		logic [STAMP_W-1:0] rel_count;
		logic [TOTAL_W-1:0] total;
		logic [RANGE_W-1:0] mrange;
		logic               colors_on;
		grant_t             owed [$];
		int                 errors, n_req, n_rel, n_reuse, n_grow, n_full, n_relerr;

		function new();
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				color_tab[i] = '0;
				free_tab[i]  = 1'b0;
			end
			used = 0;
			rel_count = '0;
			total = '0;
			mrange = 5'd2;
			colors_on = 1'b0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [4:0] val);
			if (idx == CFG_RANGE)
				mrange = val;
			else if (idx == CFG_USE_COLORS)
				colors_on = val[0];
		endfunction

		function bit usable(int i, logic [TAG_W-1:0] dev, logic [TAG_W-1:0] color);
			return free_tab[i] && dev_tab[i] == dev && (!colors_on || color_tab[i] == color);
		endfunction

		function void note_input(logic func, logic [TAG_W-1:0] dev, logic shape,
				logic [CNT_W-1:0] cnt, logic [TAG_W-1:0] color, logic [ID_W-1:0] rid);
			grant_t g;
			logic [SIZE_W-1:0] b;
			longint unsigned hi, lo, s;
			int pick, sid;
			logic [STAMP_W-1:0] age_i, age_p;
			g.id = ID_BAD;
			g.status = STAT_OK;
			b = {cnt, 2'b00};
			pick = -1;
			if (func == FUNC_REQUEST) begin
				n_req++;
				if (shape) begin
					if (mrange != 0) begin
						hi = longint'(b) * mrange;
						lo = longint'(b) / mrange;
						// Best fit at or above the request, oldest release on ties.
						for (int i = 0; i < used; i++) begin
							s = 64'(size_tab[i]);
							if (!usable(i, dev, color) || s < b || s > hi)
								continue;
							age_i = rel_count - stamp_tab[i];
							if (pick >= 0)
								age_p = rel_count - stamp_tab[pick];
							if (pick < 0 || s < size_tab[pick] ||
									(s == size_tab[pick] && age_i > age_p))
								pick = i;
						end
						if (pick >= 0) begin
							free_tab[pick] = 1'b0;
							g.id = pick[ID_W-1:0];
							n_reuse++;
						end else begin
							// Largest smaller entry, newest release on ties; it grows.
							for (int i = 0; i < used; i++) begin
								s = 64'(size_tab[i]);
								if (!usable(i, dev, color) || s < lo || s >= b)
									continue;
								age_i = rel_count - stamp_tab[i];
								if (pick >= 0)
									age_p = rel_count - stamp_tab[pick];
								if (pick < 0 || s > size_tab[pick] ||
										(s == size_tab[pick] && age_i < age_p))
									pick = i;
							end
							if (pick >= 0) begin
								total = total + (b - size_tab[pick]);
								size_tab[pick] = b;
								free_tab[pick] = 1'b0;
								g.id = pick[ID_W-1:0];
								n_grow++;
							end
						end
					end
					if (pick < 0) begin
						if (used >= NUM_ENTRIES) begin
							g.status = STAT_FULL;
							n_full++;
						end else begin
							size_tab[used] = b;
							dev_tab[used] = dev;
							free_tab[used] = 1'b0;
							total = total + b;
							g.id = used[ID_W-1:0];
							used++;
						end
					end
				end
			end else begin
				n_rel++;
				sid = int'($signed(rid));
				if (rid == ID_BAD)
					g.status = STAT_BAD_ID;
				else if (rid == ID_EXT || rid == ID_DYN)
					g.status = STAT_OK;
				else if (sid < 0 || sid >= used)
					g.status = STAT_INVALID;
				else begin
					free_tab[sid] = 1'b1;
					color_tab[sid] = color;
					stamp_tab[sid] = rel_count;
					rel_count++;
				end
				if (g.status != STAT_OK)
					n_relerr++;
			end
			g.total = total;
			owed.push_back(g);
		endfunction

		function void check_result(logic [55:0] data);
			grant_t got, exp_g;
			got = data[54:0];
			if (owed.size() == 0) begin
				$display("%0t: unexpected result id=%0d status=%0d total=%0d", $realtime,
						$signed(got.id), got.status, got.total);
				errors++;
				return;
			end
			exp_g = owed.pop_front();
			if (got.id !== exp_g.id) begin
				$display("%0t: grant id expected %0d actual %0d", $realtime,
						$signed(exp_g.id), $signed(got.id));
				errors++;
			end
			if (got.status !== exp_g.status) begin
				$display("%0t: status expected %0d actual %0d", $realtime,
						exp_g.status, got.status);
				errors++;
			end
			if (got.total !== exp_g.total) begin
				$display("%0t: total_bytes expected %0d actual %0d", $realtime,
						exp_g.total, got.total);
				errors++;
			end
			if (data[55] !== 1'b0) begin
				$display("%0t: pad bit expected 0 actual %b", $realtime, data[55]);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [4:0]  cfg_data = '0;

	allocator_scoreboard sb = new();
	bit   quiet;         // no idling on either side
	bit   hold_request;  // ask the receiver for one long hold-off
	int   idle_cycles;

	size_matched_buffer_allocator_unit #(.MAX_ENTRIES(NUM_ENTRIES)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic int gap_len();
		if (quiet || $urandom_range(0, 2) != 0)
			return 0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 60);
		return $urandom_range(1, 3);
	endfunction

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (hold_request) begin
				hold_request = 1'b0;
				stall_left = 400;
				m_tready <= 1'b0;
			end else begin
				stall_left = gap_len();
				m_tready <= (stall_left == 0);
			end
		end
	end

	// Watchdog on cycles without any transfer.
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $realtime, IDLE_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	task automatic send(logic func, logic [TAG_W-1:0] dev, logic shape,
			logic [CNT_W-1:0] cnt, logic [TAG_W-1:0] color, logic [ID_W-1:0] rid);
		int g;
		g = gap_len();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= {2'b00, rid, color, cnt, shape, dev};
		do @(posedge clk); while (!s_tready);
		sb.note_input(func, dev, shape, cnt, color, rid);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (sb.owed.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [4:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	task automatic request(logic [TAG_W-1:0] dev, logic [CNT_W-1:0] cnt,
			logic [TAG_W-1:0] color);
		send(FUNC_REQUEST, dev, 1'b1, cnt, color, '0);
	endtask

	task automatic release_id(logic [ID_W-1:0] rid, logic [TAG_W-1:0] color);
		send(FUNC_RELEASE, TAG_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
				CNT_W'({$urandom, $urandom}), color, rid);
	endtask

	task automatic random_item();
		logic [CNT_W-1:0] cnt;
		logic [TAG_W-1:0] dev, color;
		logic [ID_W-1:0]  rid;
		int               sel;
		int               pool [10] = '{0, 1, 2, 3, 4, 5, 6, 8, 12, 16};
		sel = $urandom_range(0, 99);
		dev = ($urandom_range(0, 9) < 7) ? TAG_W'($urandom_range(0, 2))
				: TAG_W'($urandom_range(0, 15));
		color = ($urandom_range(0, 9) < 6) ? TAG_W'($urandom_range(0, 1))
				: TAG_W'($urandom_range(0, 15));
		if (sel < 50) begin
			sel = $urandom_range(0, 99);
			if (sel < 60)
				cnt = CNT_W'(pool[$urandom_range(0, 9)]);
			else if (sel < 85)
				cnt = CNT_W'($urandom_range(0, 64));
			else
				cnt = CNT_W'({$urandom, $urandom});
			send(FUNC_REQUEST, dev, ($urandom_range(0, 19) != 0), cnt, color,
					ID_W'($urandom_range(0, 127)));
		end else begin
			sel = $urandom_range(0, 99);
			if (sel < 60 && sb.used > 0)
				rid = ID_W'($urandom_range(0, sb.used - 1));
			else if (sel < 75)
				rid = ID_DYN + ID_W'($urandom_range(0, 2));
			else if (sel < 85 || sb.used >= NUM_ENTRIES)
				rid = ID_W'($urandom_range(0, 127));
			else
				rid = ID_W'($urandom_range(sb.used, NUM_ENTRIES - 1));
			release_id(rid, color);
		end
	endtask

	initial begin
		int ranges [6] = '{0, 1, 16, 3, 16, 2};
		int colors [6] = '{0, 1, 0, 1, 1, 0};
		hold_request = 1'b0;
		quiet = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset settings.
		send(FUNC_REQUEST, 4'd3, 1'b0, 38'd5, 4'd0, '0);
		release_id(ID_BAD, 4'd0);
		release_id(ID_EXT, 4'd0);
		release_id(ID_DYN, 4'd0);
		release_id(7'h40, 4'd0);
		release_id(7'd5, 4'd0);
		request(4'd0, 38'd4, 4'd0);
		request(4'd0, 38'd8, 4'd0);
		request(4'd15, {CNT_W{1'b1}}, 4'd15);
		request(4'd0, 38'd0, 4'd0);
		release_id(7'd0, 4'd2);
		release_id(7'd1, 4'd3);
		request(4'd0, 38'd4, 4'd7);
		request(4'd0, 38'd12, 4'd0);
		release_id(7'd0, 4'd1);
		release_id(7'd0, 4'd9);
		release_id(7'd3, 4'd0);
		request(4'd0, 38'd0, 4'd0);
		request(4'd0, 38'd3, 4'd0);
		release_id(7'd2, 4'd15);
		request(4'd15, 38'h3F_FFFF_FFF0, 4'd0);
		release_id(7'd63, 4'd0);
		wait_idle();

		// Random phases, each under its own register settings.
		for (int p = 0; p < 6; p++) begin
			write_reg(CFG_RANGE, RANGE_W'(ranges[p]));
			write_reg(CFG_USE_COLORS, RANGE_W'(colors[p]));
			quiet = (p == 3);
			if (p == 1)
				hold_request = 1'b1;
			repeat (205) random_item();
			wait_idle();
		end

		$display("Covered %0d requests (%0d reused, %0d grown, %0d table full) and %0d releases",
				sb.n_req, sb.n_reuse, sb.n_grow, sb.n_full, sb.n_rel);
		$display("(%0d with an error status) across match ranges 0 to 16, colors on and off.",
				sb.n_relerr);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
